[hdl/bcdm_pkg.sv]
// Shared definitions for the byte-command dual motor PWM controller.
// Command characters, status codes and the speed/compare widths.
// No dependencies.
`default_nettype none

package bcdm_pkg;

	localparam int SPEED_W = 8;
	localparam int CMP_W   = 8;
	localparam int DUTY_W  = 7;

	localparam logic [7:0] CMD_STOP      = 8'h30;
	localparam logic [7:0] CMD_UP_BOTH   = 8'h31;
	localparam logic [7:0] CMD_UP_B      = 8'h32;
	localparam logic [7:0] CMD_DOWN_BOTH = 8'h33;
	localparam logic [7:0] CMD_DOWN_B    = 8'h34;
	localparam logic [7:0] CMD_Q_MAC     = 8'h61;
	localparam logic [7:0] CMD_Q_BAUD    = 8'h62;
	localparam logic [7:0] CMD_Q_STATUS  = 8'h73;
	localparam logic [7:0] CMD_Q_VERSION = 8'h74;

	localparam logic [3:0] ST_STEPPED   = 4'd0;
	localparam logic [3:0] ST_AT_LIMIT  = 4'd1;
	localparam logic [3:0] ST_REFUSED   = 4'd2;
	localparam logic [3:0] ST_STOPPED   = 4'd3;
	localparam logic [3:0] ST_MAC       = 4'd4;
	localparam logic [3:0] ST_BAUD      = 4'd5;
	localparam logic [3:0] ST_STATUS    = 4'd6;
	localparam logic [3:0] ST_VERSION   = 4'd7;
	localparam logic [3:0] ST_IGNORED   = 4'd8;

	localparam logic [CMP_W-1:0] CMP_IDLE  = 8'hFF;
	localparam logic [DUTY_W-1:0] DUTY_RST = 7'd100;

endpackage

`default_nettype wire

[hdl/byte_command_dual_motor_pwm.sv]
// Byte-command dual motor PWM controller, top level.
// Uses bcdm_pkg for command characters, status codes and widths.
// Holds the speed state, the compare registers and a shared 8-step divider.
//
// Usage: one request on the input channel carries one command byte
// (command_byte, in_valid/in_stall). Each request gives exactly one request
// on the output channel (out_valid/out_stall) carrying a status code, both
// wheel speeds and the four H-bridge compare values after the command.
// A command that maps no wheel gives its result straight from decode; a step
// on wheel B alone or on both wheels goes through load, divide and write for
// each changed wheel, A before B. A wheel at zero speed or with a saturated
// duty skips the divide steps. The single restoring divider (one quotient bit
// a cycle) turns |speed|*255 into a duty for each changed wheel in turn.
// A new byte is taken only once the result has been taken.
// One command is in flight at a time: in_stall is high from acceptance
// until the result has been taken. While out_stall is high the result
// holds and no new byte is taken.
// max_duty is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block does not enforce. Reset clears
// both speeds and all compare values to zero and sets max_duty to 100.
`default_nettype none

module byte_command_dual_motor_pwm #(
	parameter int SPEED_STEP = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [bcdm_pkg::DUTY_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   command_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [3:0]                        status_code,
	output logic signed [bcdm_pkg::SPEED_W-1:0] speed_a,
	output logic signed [bcdm_pkg::SPEED_W-1:0] speed_b,
	output logic [bcdm_pkg::CMP_W-1:0]        compare_a_fwd,
	output logic [bcdm_pkg::CMP_W-1:0]        compare_a_rev,
	output logic [bcdm_pkg::CMP_W-1:0]        compare_b_fwd,
	output logic [bcdm_pkg::CMP_W-1:0]        compare_b_rev
);
	import bcdm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD,
		S_DIV,
		S_WRITE,
		S_OUT
	} state_t;

	localparam logic signed [8:0] STEP9 = 9'(SPEED_STEP);

	state_t                      state_q;
	logic [7:0]                  cmd_q;
	logic [DUTY_W-1:0]           max_duty_q;
	logic signed [SPEED_W-1:0]   wheel_a_q;
	logic signed [SPEED_W-1:0]   wheel_b_q;
	logic [CMP_W-1:0]            cmp_a_fwd_q, cmp_a_rev_q, cmp_b_fwd_q, cmp_b_rev_q;
	logic [3:0]                  status_q;
	logic                        out_valid_q;
	logic                        map_a_q, map_b_q;
	logic                        sel_b_q;
	logic [7:0]                  rem_q;
	logic [7:0]                  dvd_q;
	logic [7:0]                  quo_q;
	logic [2:0]                  cnt_q;

	function automatic logic signed [SPEED_W-1:0] clamp9(logic signed [8:0] s,
			logic signed [8:0] lim);
		logic signed [8:0] nl;
		nl = -lim;
		if (s > lim)
			return lim[SPEED_W-1:0];
		else if (s < nl)
			return nl[SPEED_W-1:0];
		else
			return s[SPEED_W-1:0];
	endfunction

	// command decode
	logic signed [8:0]         a9, b9, lim9, nlim9;
	logic signed [SPEED_W-1:0] nxt_a, nxt_b;
	logic                      upd_a, upd_b, clr;
	logic [3:0]                dec_status;

	always_comb begin
		a9    = {wheel_a_q[SPEED_W-1], wheel_a_q};
		b9    = {wheel_b_q[SPEED_W-1], wheel_b_q};
		lim9  = {2'b00, max_duty_q};
		nlim9 = -lim9;
		nxt_a = wheel_a_q;
		nxt_b = wheel_b_q;
		upd_a = 1'b0;
		upd_b = 1'b0;
		clr   = 1'b0;
		dec_status = ST_IGNORED;
		unique case (cmd_q)
			CMD_UP_BOTH: begin
				if (a9 < lim9) begin
					nxt_a = clamp9(a9 + STEP9, lim9);
					nxt_b = clamp9(b9 + STEP9, lim9);
					upd_a = 1'b1;
					upd_b = 1'b1;
					dec_status = ({nxt_a[SPEED_W-1], nxt_a} == lim9) ? ST_AT_LIMIT : ST_STEPPED;
				end else begin
					dec_status = ST_REFUSED;
				end
			end
			CMD_DOWN_BOTH: begin
				if (a9 > nlim9) begin
					nxt_a = clamp9(a9 - STEP9, lim9);
					nxt_b = clamp9(b9 - STEP9, lim9);
					upd_a = 1'b1;
					upd_b = 1'b1;
					dec_status = ({nxt_a[SPEED_W-1], nxt_a} == nlim9) ? ST_AT_LIMIT : ST_STEPPED;
				end else begin
					dec_status = ST_REFUSED;
				end
			end
			CMD_UP_B: begin
				if (b9 < lim9) begin
					nxt_b = clamp9(b9 + STEP9, lim9);
					upd_b = 1'b1;
					dec_status = ({nxt_b[SPEED_W-1], nxt_b} == lim9) ? ST_AT_LIMIT : ST_STEPPED;
				end else begin
					dec_status = ST_REFUSED;
				end
			end
			CMD_DOWN_B: begin
				if (b9 > nlim9) begin
					nxt_b = clamp9(b9 - STEP9, lim9);
					upd_b = 1'b1;
					dec_status = ({nxt_b[SPEED_W-1], nxt_b} == nlim9) ? ST_AT_LIMIT : ST_STEPPED;
				end else begin
					dec_status = ST_REFUSED;
				end
			end
			CMD_STOP: begin
				nxt_a = '0;
				nxt_b = '0;
				clr   = 1'b1;
				dec_status = ST_STOPPED;
			end
			CMD_Q_MAC:     dec_status = ST_MAC;
			CMD_Q_BAUD:    dec_status = ST_BAUD;
			CMD_Q_STATUS:  dec_status = ST_STATUS;
			CMD_Q_VERSION: dec_status = ST_VERSION;
			default:       dec_status = ST_IGNORED;
		endcase
	end

	// duty set-up for the selected wheel: dividend = |speed| * 255
	logic signed [SPEED_W-1:0] sel_speed;
	logic [SPEED_W-1:0]        sel_neg;
	logic [DUTY_W-1:0]         mag;
	logic [14:0]               dividend;
	logic                      div_sat;
	logic [7:0]                trial;
	logic                      trial_ge;
	logic [CMP_W-1:0]          duty_cmp;

	always_comb begin
		sel_speed = sel_b_q ? wheel_b_q : wheel_a_q;
		sel_neg   = -sel_speed;
		mag       = sel_speed[SPEED_W-1] ? sel_neg[DUTY_W-1:0] : sel_speed[DUTY_W-1:0];
		dividend  = {mag, 8'h00} - {8'h00, mag};
		div_sat   = dividend >= {max_duty_q, 8'h00};
		trial     = {rem_q[6:0], dvd_q[7]};
		trial_ge  = trial >= {1'b0, max_duty_q};
		duty_cmp  = CMP_IDLE - quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			max_duty_q  <= DUTY_RST;
			wheel_a_q   <= '0;
			wheel_b_q   <= '0;
			cmp_a_fwd_q <= '0;
			cmp_a_rev_q <= '0;
			cmp_b_fwd_q <= '0;
			cmp_b_rev_q <= '0;
			status_q    <= '0;
			out_valid_q <= 1'b0;
			map_a_q     <= 1'b0;
			map_b_q     <= 1'b0;
			sel_b_q     <= 1'b0;
			rem_q       <= '0;
			dvd_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr_en)
				max_duty_q <= cfg_wr_data;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command_byte;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					wheel_a_q <= nxt_a;
					wheel_b_q <= nxt_b;
					status_q  <= dec_status;
					map_a_q   <= upd_a;
					map_b_q   <= upd_b;
					sel_b_q   <= !upd_a;
					if (clr) begin
						cmp_a_fwd_q <= '0;
						cmp_a_rev_q <= '0;
						cmp_b_fwd_q <= '0;
						cmp_b_rev_q <= '0;
					end
					if (upd_a || upd_b) begin
						state_q <= S_LOAD;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_LOAD: begin
					if (mag == '0) begin
						quo_q   <= '0;
						state_q <= S_WRITE;
					end else if (div_sat) begin
						quo_q   <= 8'hFF;
						state_q <= S_WRITE;
					end else begin
						quo_q   <= '0;
						rem_q   <= {1'b0, dividend[14:8]};
						dvd_q   <= dividend[7:0];
						cnt_q   <= 3'd7;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= trial_ge ? (trial - {1'b0, max_duty_q}) : trial;
					dvd_q <= {dvd_q[6:0], 1'b0};
					quo_q <= {quo_q[6:0], trial_ge};
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd0)
						state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (sel_b_q) begin
						cmp_b_fwd_q <= sel_speed[SPEED_W-1] ? CMP_IDLE : duty_cmp;
						cmp_b_rev_q <= sel_speed[SPEED_W-1] ? duty_cmp : CMP_IDLE;
						map_b_q     <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						cmp_a_fwd_q <= sel_speed[SPEED_W-1] ? CMP_IDLE : duty_cmp;
						cmp_a_rev_q <= sel_speed[SPEED_W-1] ? duty_cmp : CMP_IDLE;
						map_a_q     <= 1'b0;
						if (map_b_q) begin
							sel_b_q <= 1'b1;
							state_q <= S_LOAD;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign status_code   = status_q;
	assign speed_a       = wheel_a_q;
	assign speed_b       = wheel_b_q;
	assign compare_a_fwd = cmp_a_fwd_q;
	assign compare_a_rev = cmp_a_rev_q;
	assign compare_b_fwd = cmp_b_fwd_q;
	assign compare_b_rev = cmp_b_rev_q;

	// speeds never leave the symmetric range
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_a_q != -8'sd128 && wheel_b_q != -8'sd128)
		else $error("wheel speed out of range");

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid && !map_a_q && !map_b_q)
		else $error("input ready while a request is in flight");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == 3'd0 |=> state_q == S_WRITE)
		else $error("divider overran its bit count");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_code <= ST_IGNORED)
		else $error("status code out of range");

endmodule

`default_nettype wire
